@@ sv/sine_pkg.sv @@
// Package: types and constants for the sorted interior node engine.
package sine_pkg;
    localparam int MAX_KEYS  = 15;
    localparam int KEY_W     = 64;
    localparam int POS_W     = 4;
    localparam int SPLIT_LOW = 7;

    typedef enum logic [1:0] {
        CMD_SET_FIRST = 2'd0,
        CMD_INSERT    = 2'd1,
        CMD_DESCEND   = 2'd2,
        CMD_SPLIT     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUP       = 2'd2,
        ST_NOT_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT,
        S_SPLIT
    } t_state;

    // Per-cell control broadcast from the controller.
    typedef struct packed {
        logic             scan;      // compare stored key against probe
        logic             ins;       // open a gap at ins_pos and write
        logic             drop_hi;   // split: discard upper entries
        logic [POS_W-1:0] ins_pos;
    } t_cell_ctl;
endpackage

@@ sv/sorted_interior_node_engine.sv @@
// Top level: sorted interior node engine, a chain of 15 key cells plus controller.
// Split emits 8 results, one per cycle while m_axis_tready is high.
// The next command is taken once the last result of the previous one has left.
// Reset (synchronous, active low) empties the node; keys and children hold no reset.
module sorted_interior_node_engine #(
    parameter int CHILD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // key[63:0], child_id[95:64]
    input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // key_out[63:0], child_out[95:64]
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    output logic         m_axis_tlast
);
    localparam int NK = sine_pkg::MAX_KEYS;
    localparam int KW = sine_pkg::KEY_W;
    localparam int CW = (CHILD_BITS < 32) ? CHILD_BITS : 32;

    sine_pkg::t_cell_ctl ctl;
    logic                latch;
    logic [KW-1:0]       r_probe;
    logic [CHILD_BITS-1:0] r_pchild;
    logic [CHILD_BITS-1:0] r_child0;
    logic [NK-1:0]       le, eq, vld;
    logic [NK*KW-1:0]    keys;
    logic [NK*CHILD_BITS-1:0] childs;
    logic [KW-1:0]       c_key [NK+1];
    logic [CHILD_BITS-1:0] c_child [NK+1];
    logic                c_valid [NK+1];
    logic [KW-1:0]       key_ctl;
    logic [CHILD_BITS-1:0] child_ctl;
    logic [CHILD_BITS-1:0] in_child;

    always_comb begin
        in_child = '0;
        in_child[CW-1:0] = s_axis_tdata[64 +: CW];
    end

    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_probe  <= s_axis_tdata[KW-1:0];
            r_pchild <= in_child;
        end
        if (latch && s_axis_tuser == sine_pkg::CMD_SET_FIRST) r_child0 <= in_child;
    end

    assign c_key[0]   = '0;
    assign c_child[0] = '0;
    assign c_valid[0] = 1'b0;

    for (genvar g = 0; g < NK; g++) begin : g_cell
        sine_cell #(.CHILD_BITS(CHILD_BITS), .POS(g)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_probe      (r_probe),
            .i_probe_child(r_pchild),
            .i_left_key   (c_key[g]),
            .i_left_child (c_child[g]),
            .i_left_valid (c_valid[g]),
            .o_key        (c_key[g+1]),
            .o_child      (c_child[g+1]),
            .o_valid      (c_valid[g+1]),
            .o_le         (le[g]),
            .o_eq         (eq[g])
        );
        assign vld[g] = c_valid[g+1];
        assign keys[g*KW +: KW] = c_key[g+1];
        assign childs[g*CHILD_BITS +: CHILD_BITS] = c_child[g+1];
    end

    sine_ctrl #(.CHILD_BITS(CHILD_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_le       (le),
        .i_eq       (eq),
        .i_valid    (vld),
        .i_keys     (keys),
        .i_childs   (childs),
        .i_child0   (r_child0),
        .o_ctl      (ctl),
        .o_latch    (latch),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_status   (m_axis_tuser),
        .o_key      (key_ctl),
        .o_child    (child_ctl),
        .o_last     (m_axis_tlast)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[KW-1:0] = key_ctl;
        m_axis_tdata[KW +: CW] = child_ctl[CW-1:0];
    end
endmodule

@@ sv/sine_cell.sv @@
// One sorted position of the node: key, right child, valid, compare flags.
module sine_cell #(
    parameter int CHILD_BITS = 32,
    parameter int POS        = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sine_pkg::t_cell_ctl          i_ctl,
    input  logic [sine_pkg::KEY_W-1:0]   i_probe,
    input  logic [CHILD_BITS-1:0]        i_probe_child,
    input  logic [sine_pkg::KEY_W-1:0]   i_left_key,
    input  logic [CHILD_BITS-1:0]        i_left_child,
    input  logic                         i_left_valid,
    output logic [sine_pkg::KEY_W-1:0]   o_key,
    output logic [CHILD_BITS-1:0]        o_child,
    output logic                         o_valid,
    output logic                         o_le,
    output logic                         o_eq
);
    localparam logic [sine_pkg::POS_W-1:0] MY_POS = sine_pkg::POS_W'(POS);

    logic [sine_pkg::KEY_W-1:0] r_key;
    logic [CHILD_BITS-1:0]      r_child;
    logic                       r_valid;
    logic                       r_le;
    logic                       r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_le    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.scan) begin
                r_le <= r_valid && (r_key <= i_probe);
                r_eq <= r_valid && (r_key == i_probe);
            end
            if (i_ctl.ins) begin
                if (MY_POS > i_ctl.ins_pos) begin
                    r_valid <= i_left_valid;
                end else if (MY_POS == i_ctl.ins_pos) begin
                    r_valid <= 1'b1;
                end
            end else if (i_ctl.drop_hi && MY_POS >= sine_pkg::POS_W'(sine_pkg::SPLIT_LOW)) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (MY_POS > i_ctl.ins_pos) begin
                r_key   <= i_left_key;
                r_child <= i_left_child;
            end else if (MY_POS == i_ctl.ins_pos) begin
                r_key   <= i_probe;
                r_child <= i_probe_child;
            end
        end
    end

    assign o_key   = r_key;
    assign o_child = r_child;
    assign o_valid = r_valid;
    assign o_le    = r_le;
    assign o_eq    = r_eq;
endmodule

@@ sv/sine_ctrl.sv @@
// Controller: command decode, result selection and split sequencing.
module sine_ctrl #(
    parameter int CHILD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic [sine_pkg::MAX_KEYS-1:0]         i_le,
    input  logic [sine_pkg::MAX_KEYS-1:0]         i_eq,
    input  logic [sine_pkg::MAX_KEYS-1:0]         i_valid,
    input  logic [sine_pkg::MAX_KEYS*sine_pkg::KEY_W-1:0] i_keys,
    input  logic [sine_pkg::MAX_KEYS*CHILD_BITS-1:0]      i_childs,
    input  logic [CHILD_BITS-1:0]                 i_child0,
    output sine_pkg::t_cell_ctl                   o_ctl,
    output logic                                  o_latch,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic [sine_pkg::KEY_W-1:0]            o_key,
    output logic [CHILD_BITS-1:0]                 o_child,
    output logic                                  o_last
);
    localparam int PW = sine_pkg::POS_W;

    sine_pkg::t_state r_state, n_state;
    logic [1:0]       r_cmd;
    logic [PW-1:0]    r_idx, n_idx;
    logic [1:0]       r_status, n_status;
    logic [sine_pkg::KEY_W-1:0] r_key, n_key;
    logic [CHILD_BITS-1:0]      r_child, n_child;
    logic             r_last, n_last;
    logic             r_ov, n_ov;

    logic [PW-1:0]    le_cnt;
    logic             full;
    logic             sel_le;

    always_comb begin
        le_cnt = '0;
        for (int i = 0; i < sine_pkg::MAX_KEYS; i++) begin
            le_cnt = le_cnt + PW'(i_le[i]);
        end
    end
    assign full = i_valid[sine_pkg::MAX_KEYS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sine_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sine_pkg::S_IDLE && i_in_valid) r_cmd <= i_cmd;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_key    <= n_key;
        r_child  <= n_child;
        r_last   <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_status   = r_status;
        n_key      = r_key;
        n_child    = r_child;
        n_last     = r_last;
        n_ov       = r_ov;
        o_in_ready = 1'b0;
        o_latch    = 1'b0;
        o_ctl      = '0;
        sel_le     = 1'b0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            sine_pkg::S_IDLE: begin
                o_in_ready = !r_ov;
                if (i_in_valid && !r_ov) begin
                    o_latch = 1'b1;
                    n_state = sine_pkg::S_SCAN;
                end
            end
            sine_pkg::S_SCAN: begin
                o_ctl.scan = 1'b1;
                n_state    = sine_pkg::S_RESULT;
            end
            sine_pkg::S_RESULT: begin
                n_status = sine_pkg::ST_OK;
                n_key    = '0;
                n_child  = '0;
                n_last   = 1'b1;
                n_ov     = 1'b1;
                n_state  = sine_pkg::S_IDLE;
                case (sine_pkg::t_cmd'(r_cmd))
                    sine_pkg::CMD_SET_FIRST: ;
                    sine_pkg::CMD_INSERT: begin
                        if (full) begin
                            n_status = sine_pkg::ST_FULL;
                        end else if (|i_eq) begin
                            n_status = sine_pkg::ST_DUP;
                        end else begin
                            o_ctl.ins     = 1'b1;
                            o_ctl.ins_pos = le_cnt;
                        end
                    end
                    sine_pkg::CMD_DESCEND: begin
                        sel_le = 1'b1;
                        if (le_cnt == '0) n_child = i_child0;
                        else n_child = i_childs[(le_cnt - PW'(1))*CHILD_BITS +: CHILD_BITS];
                    end
                    sine_pkg::CMD_SPLIT: begin
                        if (!full) begin
                            n_status = sine_pkg::ST_NOT_FULL;
                        end else begin
                            n_key   = i_keys[sine_pkg::SPLIT_LOW*sine_pkg::KEY_W +: sine_pkg::KEY_W];
                            n_child = i_childs[sine_pkg::SPLIT_LOW*CHILD_BITS +: CHILD_BITS];
                            n_last  = 1'b0;
                            n_idx   = PW'(sine_pkg::SPLIT_LOW + 1);
                            n_state = sine_pkg::S_SPLIT;
                        end
                    end
                    default: ;
                endcase
            end
            sine_pkg::S_SPLIT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_key   = i_keys[r_idx*sine_pkg::KEY_W +: sine_pkg::KEY_W];
                    n_child = i_childs[r_idx*CHILD_BITS +: CHILD_BITS];
                    n_last  = (r_idx == PW'(sine_pkg::MAX_KEYS - 1));
                    n_idx   = r_idx + PW'(1);
                    if (n_last) begin
                        o_ctl.drop_hi = 1'b1;
                        n_state       = sine_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = sine_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_ov && !sel_le;
    assign o_status    = r_status;
    assign o_key       = r_key;
    assign o_child     = r_child;
    assign o_last      = r_last;
endmodule

@@ sv/sine_checker.sv @@
// Checker: port-level properties of the sorted interior node engine.
module sine_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != sine_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error status not final");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");

    a_no_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("two transfers back to back");
endmodule

bind sorted_interior_node_engine sine_checker u_sine_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
